[rtl/dynamic_time_warping_distance_core_defines.svh]
// ----------------------------------------------------------------------------
// DTW distance core assertion macros
// Clocked assertion helpers, disabled during reset; ASSERT_OFF removes them.
// ----------------------------------------------------------------------------
`ifndef DYNAMIC_TIME_WARPING_DISTANCE_CORE_DEFINES_SVH
`define DYNAMIC_TIME_WARPING_DISTANCE_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
`define DTWD_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define DTWD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define DTWD_ASSERT_SAME(label, ante, cons, msg)
`define DTWD_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

[rtl/dtwd_pkg.sv]
// ----------------------------------------------------------------------------
// DTW distance package
// Shared sizes, codes, the sequencer state type and a small helper function.
// ----------------------------------------------------------------------------
package dtwd_pkg;

  localparam int MAX_POINTS = 256;
  localparam int MAX_DIM    = 4;
  localparam int COORD_W    = 20;
  localparam int PT_IDX_W   = $clog2(MAX_POINTS);
  localparam int CNT_W      = PT_IDX_W + 1;
  localparam int DIM_IDX_W  = $clog2(MAX_DIM);
  localparam int ADDR_W     = PT_IDX_W + DIM_IDX_W;
  localparam int DIFF_W     = COORD_W + 1;
  localparam int SQ_W       = 2 * DIFF_W;
  localparam int SUM_W      = SQ_W + DIM_IDX_W;
  localparam int ROOT_W     = SUM_W / 2;
  localparam int CELL_W     = 32;
  localparam int DIM_W      = 3;

  localparam logic [CELL_W-1:0] CELL_INF = '1;
  localparam logic [DIM_W-1:0]  DIM_RESET = DIM_W'(3);

  typedef enum logic [1:0] {
    KIND_P       = 2'd0,
    KIND_Q       = 2'd1,
    KIND_COMPUTE = 2'd2,
    KIND_NONE    = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_EMPTY    = 2'd1,
    STATUS_OVERFLOW = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADDR,
    S_DIFF,
    S_SQ,
    S_ROOT_GO,
    S_ROOT,
    S_ADD
  } state_t;

  // Root unit request and answer.
  typedef struct packed {
    logic              start;
    logic [SUM_W-1:0]  radicand;
  } sqrt_req_t;

  typedef struct packed {
    logic              done;
    logic [ROOT_W-1:0] root;
  } sqrt_rsp_t;

  // Last coordinate index of a point for a given dim (0 acts as 1, large clamps).
  function automatic logic [DIM_IDX_W-1:0] last_coord(input logic [DIM_W-1:0] d);
    logic [DIM_IDX_W-1:0] r;
    if (d == '0) begin
      r = '0;
    end else if (d > DIM_W'(MAX_DIM)) begin
      r = DIM_IDX_W'(MAX_DIM - 1);
    end else begin
      r = DIM_IDX_W'(d - DIM_W'(1));
    end
    return r;
  endfunction

endpackage

[rtl/dtwd_ram.sv]
// ----------------------------------------------------------------------------
// DTW distance generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module dtwd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Synchronous write and read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/dtwd_isqrt.sv]
// ----------------------------------------------------------------------------
// DTW distance integer square root
// Restoring digit-by-digit floor square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module dtwd_isqrt (
  input  logic                clk,
  input  logic                rst_n,
  input  dtwd_pkg::sqrt_req_t req,
  output dtwd_pkg::sqrt_rsp_t rsp
);
  import dtwd_pkg::*;

  localparam int CNT_BITS = $clog2(ROOT_W);

  logic [SUM_W-1:0]    rad_r;
  logic [ROOT_W+1:0]   rem_r;
  logic [ROOT_W-1:0]   root_r;
  logic [CNT_BITS-1:0] cnt_r;
  logic                run_r;
  logic                done_r;

  logic [ROOT_W+3:0]   trial;
  logic [ROOT_W+3:0]   sub;
  logic                fits;

  // Bring down two radicand bits and try the next root bit.
  always_comb begin
    trial = {rem_r, rad_r[SUM_W-1 -: 2]};
    sub   = {2'b00, root_r, 2'b01};
    fits  = (trial >= sub);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + CNT_BITS'(1);
        if (cnt_r == CNT_BITS'(ROOT_W - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath of the root iteration.
  always_ff @(posedge clk) begin
    if (req.start) begin
      rad_r  <= req.radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (run_r) begin
      rad_r <= {rad_r[SUM_W-3:0], 2'b00};
      if (fits) begin
        rem_r  <= (ROOT_W+2)'(trial - sub);
        root_r <= {root_r[ROOT_W-2:0], 1'b1};
      end else begin
        rem_r  <= trial[ROOT_W+1:0];
        root_r <= {root_r[ROOT_W-2:0], 1'b0};
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.root = root_r;

endmodule

[rtl/dynamic_time_warping_distance_core.sv]
// ----------------------------------------------------------------------------
// DTW distance core
// Loads two curves and computes their dynamic time warping distance.
// ----------------------------------------------------------------------------
// Coordinate requests (kind 0 for curve p, 1 for curve q) may be issued back
// to back. A compute request keeps busy high while the table is walked one
// cell at a time: each cell reads its coordinate pairs one at a time from the
// curve memories (address, difference and square steps per coordinate),
// starts the bit-serial square root unit and waits until its answer is taken,
// and then updates the row memory.
// An empty curve answers in the cycle after the request. The result is shown
// for a single cycle on out_valid and cannot be held off by the receiver.
// ----------------------------------------------------------------------------
`include "dynamic_time_warping_distance_core_defines.svh"

module dynamic_time_warping_distance_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          in_kind,
  input  logic signed [dtwd_pkg::COORD_W-1:0] in_coord,
  output logic                                out_valid,
  output logic [dtwd_pkg::CELL_W-1:0]         out_distance,
  output logic [1:0]                          out_status,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [dtwd_pkg::DIM_W-1:0]          cfg_dim
);
  import dtwd_pkg::*;

  state_t state_r, state_nxt;

  logic [DIM_W-1:0]     dim_r;
  logic [CNT_W-1:0]     p_cnt_r, q_cnt_r;
  logic [DIM_IDX_W-1:0] p_ci_r, q_ci_r;
  logic                 ovf_r;
  logic [CNT_W-1:0]     m1_r, m2_r;
  logic                 ovf_hold_r;
  logic [PT_IDX_W-1:0]  i_r, j_r;
  logic [DIM_IDX_W-1:0] k_r;
  logic signed [DIFF_W-1:0] diff_r;
  logic [SUM_W-1:0]     sum_r;
  logic [CELL_W-1:0]    up_r, left_r, diag_r;
  logic                 out_valid_r;
  logic [CELL_W-1:0]    out_dist_r;
  logic [1:0]           out_status_r;

  logic [COORD_W-1:0]   p_rd, q_rd;
  logic [CELL_W-1:0]    row_rd;
  logic                 rd_en, row_we;
  logic                 p_we, q_we;
  sqrt_req_t            sq_req;
  sqrt_rsp_t            sq_rsp;

  logic                 accept, compute_req, empty_req;
  logic [DIM_IDX_W-1:0] last_k;
  logic                 last_j, last_i;
  logic [DIFF_W-1:0]    mag;
  logic [SQ_W-1:0]      sq;
  logic [CELL_W-1:0]    up_eff, best, cell_val;
  logic [CELL_W:0]      cell_sum;

  assign accept      = start && !busy;
  assign compute_req = accept && (in_kind == KIND_COMPUTE);
  assign empty_req   = (p_cnt_r == '0) || (q_cnt_r == '0);
  assign last_k      = last_coord(dim_r);
  assign last_j      = ({1'b0, j_r} == m2_r - CNT_W'(1));
  assign last_i      = ({1'b0, i_r} == m1_r - CNT_W'(1));
  assign p_we = accept && (in_kind == KIND_P) && (p_cnt_r < CNT_W'(MAX_POINTS));
  assign q_we = accept && (in_kind == KIND_Q) && (q_cnt_r < CNT_W'(MAX_POINTS));

  // Curve and row memories.
  dtwd_ram #(.WIDTH(COORD_W), .DEPTH(MAX_POINTS * MAX_DIM)) u_p_ram (
    .clk     (clk),
    .we      (p_we),
    .wr_addr ({p_cnt_r[PT_IDX_W-1:0], p_ci_r}),
    .wr_data (in_coord),
    .rd_en   (rd_en),
    .rd_addr ({i_r, k_r}),
    .rd_data (p_rd)
  );

  dtwd_ram #(.WIDTH(COORD_W), .DEPTH(MAX_POINTS * MAX_DIM)) u_q_ram (
    .clk     (clk),
    .we      (q_we),
    .wr_addr ({q_cnt_r[PT_IDX_W-1:0], q_ci_r}),
    .wr_data (in_coord),
    .rd_en   (rd_en),
    .rd_addr ({j_r, k_r}),
    .rd_data (q_rd)
  );

  dtwd_ram #(.WIDTH(CELL_W), .DEPTH(MAX_POINTS)) u_row_ram (
    .clk     (clk),
    .we      (row_we),
    .wr_addr (j_r),
    .wr_data (cell_val),
    .rd_en   (rd_en),
    .rd_addr (j_r),
    .rd_data (row_rd)
  );

  dtwd_isqrt u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (sq_req),
    .rsp   (sq_rsp)
  );

  // Squared magnitude and the cell update.
  always_comb begin
    mag      = diff_r[DIFF_W-1] ? DIFF_W'(-diff_r) : DIFF_W'(diff_r);
    sq       = SQ_W'(mag) * SQ_W'(mag);
    up_eff   = (i_r == '0) ? CELL_INF : up_r;
    best     = up_eff;
    if (left_r < best) begin
      best = left_r;
    end
    if (diag_r < best) begin
      best = diag_r;
    end
    cell_sum = {1'b0, CELL_W'(sq_rsp.root)} + {1'b0, best};
    cell_val = cell_sum[CELL_W] ? CELL_INF : cell_sum[CELL_W-1:0];
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (compute_req && !empty_req) begin
          state_nxt = S_ADDR;
        end
      end
      S_ADDR:    state_nxt = S_DIFF;
      S_DIFF:    state_nxt = S_SQ;
      S_SQ:      state_nxt = (k_r == last_k) ? S_ROOT_GO : S_ADDR;
      S_ROOT_GO: state_nxt = S_ROOT;
      S_ROOT: begin
        if (sq_rsp.done) begin
          state_nxt = S_ADD;
        end
      end
      S_ADD:     state_nxt = (last_j && last_i) ? S_IDLE : S_ADDR;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // Control outputs per state.
  always_comb begin
    busy            = (state_r != S_IDLE);
    rd_en           = (state_r == S_ADDR);
    row_we          = (state_r == S_ADD);
    sq_req.start    = (state_r == S_ROOT_GO);
    sq_req.radicand = sum_r;
  end

  assign cfg_ready = 1'b1;

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      dim_r       <= DIM_RESET;
      p_cnt_r     <= '0;
      q_cnt_r     <= '0;
      p_ci_r      <= '0;
      q_ci_r      <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        dim_r <= cfg_dim;
      end
      // Coordinate loads.
      if (accept && (in_kind == KIND_P)) begin
        if (!p_we) begin
          ovf_r <= 1'b1;
        end else if (p_ci_r >= last_k) begin
          p_ci_r  <= '0;
          p_cnt_r <= p_cnt_r + CNT_W'(1);
        end else begin
          p_ci_r <= p_ci_r + DIM_IDX_W'(1);
        end
      end
      if (accept && (in_kind == KIND_Q)) begin
        if (!q_we) begin
          ovf_r <= 1'b1;
        end else if (q_ci_r >= last_k) begin
          q_ci_r  <= '0;
          q_cnt_r <= q_cnt_r + CNT_W'(1);
        end else begin
          q_ci_r <= q_ci_r + DIM_IDX_W'(1);
        end
      end
      // A compute request takes the counts and clears the curves.
      if (compute_req) begin
        p_cnt_r <= '0;
        q_cnt_r <= '0;
        p_ci_r  <= '0;
        q_ci_r  <= '0;
        ovf_r   <= 1'b0;
        if (empty_req) begin
          out_valid_r <= 1'b1;
        end
      end
      if ((state_r == S_ADD) && last_j && last_i) begin
        out_valid_r <= 1'b1;
      end
    end
  end

  // Table walk datapath.
  always_ff @(posedge clk) begin
    if (compute_req) begin
      m1_r         <= p_cnt_r;
      m2_r         <= q_cnt_r;
      ovf_hold_r   <= ovf_r;
      i_r          <= '0;
      j_r          <= '0;
      k_r          <= '0;
      diag_r       <= '0;
      left_r       <= CELL_INF;
      out_dist_r   <= CELL_INF;
      out_status_r <= STATUS_EMPTY;
    end
    case (state_r)
      S_DIFF: begin
        diff_r <= $signed({q_rd[COORD_W-1], q_rd}) - $signed({p_rd[COORD_W-1], p_rd});
        if (k_r == '0) begin
          up_r <= row_rd;
        end
      end
      S_SQ: begin
        sum_r <= ((k_r == '0) ? '0 : sum_r) + SUM_W'(sq);
        k_r   <= (k_r == last_k) ? '0 : k_r + DIM_IDX_W'(1);
      end
      S_ADD: begin
        if (last_j) begin
          j_r    <= '0;
          i_r    <= i_r + PT_IDX_W'(1);
          diag_r <= CELL_INF;
          left_r <= CELL_INF;
        end else begin
          j_r    <= j_r + PT_IDX_W'(1);
          diag_r <= up_eff;
          left_r <= cell_val;
        end
        if (last_j && last_i) begin
          out_dist_r   <= cell_val;
          out_status_r <= ovf_hold_r ? STATUS_OVERFLOW : STATUS_OK;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid    = out_valid_r;
  assign out_distance = out_dist_r;
  assign out_status   = out_status_r;

  // Checks on the sequencer and the result.
  `DTWD_ASSERT_SAME(a_empty_inf, out_valid && (out_status == STATUS_EMPTY), out_distance == CELL_INF, "empty curve result is not infinity")
  `DTWD_ASSERT_SAME(a_row_addr, row_we, {1'b0, j_r} < m2_r, "row write beyond the q curve")
  `DTWD_ASSERT_NEXT(a_walk_done, (state_r == S_ADD) && last_j && last_i, out_valid && !busy, "last cell did not produce a result")

endmodule

[sim/tb.sv]
// ----------------------------------------------------------------------------
// DTW distance core testbench
// Loads random and corner-case curves, issues compute requests and checks
// each distance and status against a cycle-free model of the table walk.
// ----------------------------------------------------------------------------
module tb;
  import dtwd_pkg::*;

  typedef struct {
    kind_t                     kind;
    logic signed [COORD_W-1:0] coord;
  } dtw_req_t;

  typedef struct {
    logic [CELL_W-1:0] distance;
    status_t           status;
  } dtw_res_t;

  logic                      clk;
  logic                      rst_n;
  logic                      start;
  logic                      busy;
  logic [1:0]                in_kind;
  logic signed [COORD_W-1:0] in_coord;
  logic                      out_valid;
  logic [CELL_W-1:0]         out_distance;
  logic [1:0]                out_status;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [DIM_W-1:0]          cfg_dim;

  dtw_req_t req_queue[$];
  dtw_res_t dist_queue[$];
  int       idle_pct;
  int       errors;
  int       req_total;
  int       quiet_cycles;

  // Shadow state of the core.
  logic [COORD_W-1:0] p_mem [MAX_POINTS*MAX_DIM];
  logic [COORD_W-1:0] q_mem [MAX_POINTS*MAX_DIM];
  logic [CELL_W-1:0]  row [MAX_POINTS+1];
  int                 p_cnt, q_cnt, p_ci, q_ci;
  bit                 ovf_seen;
  logic [DIM_W-1:0]   dim_reg;

  dynamic_time_warping_distance_core dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_kind(in_kind), .in_coord(in_coord),
    .out_valid(out_valid), .out_distance(out_distance), .out_status(out_status),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_dim(cfg_dim)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int eff_dim(input logic [DIM_W-1:0] d);
    if (d == 0) return 1;
    if (d > MAX_DIM) return MAX_DIM;
    return int'(d);
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned x);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Euclidean distance between p point pi and q point qj, floor root.
  function automatic logic [CELL_W-1:0] point_gap(input int pi, input int qj, input int d);
    longint unsigned sum;
    longint          diff;
    sum = 0;
    for (int k = 0; k < d; k++) begin
      diff = longint'($signed(q_mem[qj*MAX_DIM+k])) - longint'($signed(p_mem[pi*MAX_DIM+k]));
      if (diff < 0) diff = -diff;
      sum += longint'(diff) * longint'(diff);
    end
    return CELL_W'(int_sqrt(sum));
  endfunction

  function automatic logic [CELL_W-1:0] sat_add(input logic [CELL_W-1:0] a,
                                                input logic [CELL_W-1:0] b);
    logic [CELL_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CELL_W] ? CELL_INF : s[CELL_W-1:0];
  endfunction

  // Apply one accepted request to the shadow state; queue the expected answer of a compute.
  task automatic predict_dtw(input dtw_req_t r);
    logic [CELL_W-1:0] diag, up, best;
    dtw_res_t          res;
    int                d;
    d = eff_dim(dim_reg);
    case (r.kind)
      KIND_P: begin
        if (p_cnt >= MAX_POINTS) begin
          ovf_seen = 1;
        end else begin
          p_mem[p_cnt*MAX_DIM+p_ci] = r.coord;
          if (p_ci + 1 >= d) begin
            p_ci = 0;
            p_cnt++;
          end else begin
            p_ci++;
          end
        end
      end
      KIND_Q: begin
        if (q_cnt >= MAX_POINTS) begin
          ovf_seen = 1;
        end else begin
          q_mem[q_cnt*MAX_DIM+q_ci] = r.coord;
          if (q_ci + 1 >= d) begin
            q_ci = 0;
            q_cnt++;
          end else begin
            q_ci++;
          end
        end
      end
      KIND_COMPUTE: begin
        if (p_cnt == 0 || q_cnt == 0) begin
          res.distance = CELL_INF;
          res.status   = STATUS_EMPTY;
        end else begin
          row[0] = '0;
          for (int j = 1; j <= q_cnt; j++) row[j] = CELL_INF;
          for (int i = 1; i <= p_cnt; i++) begin
            diag = row[0];
            row[0] = CELL_INF;
            for (int j = 1; j <= q_cnt; j++) begin
              up = row[j];
              best = up;
              if (row[j-1] < best) best = row[j-1];
              if (diag < best) best = diag;
              diag = up;
              row[j] = sat_add(point_gap(i-1, j-1, d), best);
            end
          end
          res.distance = row[q_cnt];
          res.status   = ovf_seen ? STATUS_OVERFLOW : STATUS_OK;
        end
        p_cnt = 0; q_cnt = 0; p_ci = 0; q_ci = 0; ovf_seen = 0;
        dist_queue.push_back(res);
      end
      default: ;
    endcase
  endtask

  // Driver: one request per handshake, gaps at the phase's idle rate.
  always @(posedge clk) begin
    dtw_req_t r;
    bit       taken;
    if (rst_n) begin
      taken = start && !busy;
      if (taken) predict_dtw('{kind_t'(in_kind), in_coord});
      if (!start || taken) begin
        if (req_queue.size() > 0 && $urandom_range(99) >= idle_pct) begin
          r = req_queue.pop_front();
          start    <= 1'b1;
          in_kind  <= r.kind;
          in_coord <= r.coord;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every strobe is matched with the oldest expected answer.
  always @(posedge clk) begin
    dtw_res_t e;
    if (rst_n && out_valid) begin
      if (dist_queue.size() == 0) begin
        $display("%0t: unexpected result distance %h status %0d",
                 $time, out_distance, out_status);
        errors++;
      end else begin
        e = dist_queue.pop_front();
        if (out_distance !== e.distance) begin
          $display("%0t: distance expected %h actual %h", $time, e.distance, out_distance);
          errors++;
        end
        if (out_status !== e.status) begin
          $display("%0t: status expected %0d actual %0d", $time, e.status, out_status);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles without any handshake.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready) || !rst_n) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= 200000) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  function automatic logic signed [COORD_W-1:0] rand_coord();
    case ($urandom_range(7))
      0: return {1'b1, {(COORD_W-1){1'b0}}};
      1: return {1'b0, {(COORD_W-1){1'b1}}};
      2, 3: return COORD_W'($urandom_range(1023)) - COORD_W'(512);
      default: return COORD_W'($urandom);
    endcase
  endfunction

  task automatic push_req(input kind_t k, input logic signed [COORD_W-1:0] c);
    req_queue.push_back('{k, c});
    req_total++;
  endtask

  // One curve pair with random content, ending in a compute request.
  task automatic push_curve_pair(input int np, input int nq, input int d);
    int pc, qc;
    pc = 0;
    qc = 0;
    while (pc < np*d || qc < nq*d) begin
      if ($urandom_range(19) == 0) push_req(KIND_NONE, rand_coord());
      if (qc >= nq*d || (pc < np*d && $urandom_range(1))) begin
        push_req(KIND_P, rand_coord());
        pc++;
      end else begin
        push_req(KIND_Q, rand_coord());
        qc++;
      end
    end
    // A trailing unfinished point is ignored by the compute.
    if (d > 1 && $urandom_range(7) == 0) begin
      for (int k = $urandom_range(d-1, 1); k > 0; k--)
        push_req($urandom_range(1) ? KIND_P : KIND_Q, rand_coord());
    end
    push_req(KIND_COMPUTE, rand_coord());
  endtask

  // Wait until every request has gone in and every answer has come back.
  task automatic drain();
    while (req_queue.size() != 0 || start || busy || dist_queue.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_dim(input logic [DIM_W-1:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_dim   <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    dim_reg = v;
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [DIM_W-1:0] dims[7] = '{0, 1, 2, 3, 4, 5, 7};
    int               pcts[4] = '{0, 60, 0, 14};
    int               d, goal;
    rst_n = 1'b0; start = 1'b0; in_kind = KIND_NONE; in_coord = '0;
    cfg_valid = 1'b0; cfg_dim = DIM_RESET;
    errors = 0; req_total = 0; idle_pct = 0; quiet_cycles = 0;
    p_cnt = 0; q_cnt = 0; p_ci = 0; q_ci = 0; ovf_seen = 0; dim_reg = DIM_RESET;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty curves, extremes, ignored kind, partial point.
    push_req(KIND_COMPUTE, '0);
    repeat (3) push_req(KIND_P, '0);
    push_req(KIND_COMPUTE, '0);
    repeat (3) push_req(KIND_P, {1'b0, {(COORD_W-1){1'b1}}});
    push_req(KIND_NONE, '1);
    repeat (3) push_req(KIND_Q, {1'b1, {(COORD_W-1){1'b0}}});
    push_req(KIND_P, 20'sd5);
    push_req(KIND_COMPUTE, '0);
    repeat (3) push_req(KIND_P, 20'sd256);
    repeat (3) push_req(KIND_Q, -20'sd256);
    push_req(KIND_COMPUTE, '1);

    // Curve full: one point too many at dim 1.
    write_dim(3'd1);
    for (int i = 0; i <= MAX_POINTS; i++) push_req(KIND_P, rand_coord());
    push_req(KIND_Q, rand_coord());
    push_req(KIND_COMPUTE, '0);

    // Random phases over the listed dims and all idle rates.
    for (int ph = 0; ph < 10; ph++) begin
      write_dim(dims[ph % 7]);
      idle_pct = pcts[ph % 4];
      d = eff_dim(dims[ph % 7]);
      goal = req_total + 120;
      while (req_total < goal) begin
        if ($urandom_range(9) == 0)
          push_curve_pair($urandom_range(1) ? 0 : $urandom_range(3), $urandom_range(3), d);
        else
          push_curve_pair($urandom_range(6, 1), $urandom_range(6, 1), d);
      end
    end

    drain();
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
